// File: hw/rtl/ids_pkg.sv
// Package with the shared types, constants and month table of the date span block.
package ids_pkg;

    localparam int DAY_W   = 5;
    localparam int MONTH_W = 4;
    localparam int YEAR_W  = 14;
    localparam int ORD_W   = 23;
    localparam int SPAN_W  = 22;

    // Widths used by the shared multiplier.
    localparam int MUL_A_W = YEAR_W + 1;
    localparam int MUL_B_W = 13;
    localparam int PROD_W  = MUL_A_W + MUL_B_W;

    // ceil(y / 100) is taken as floor((y + 99) * 5243 / 2^19), exact below 43600.
    localparam logic [MUL_B_W-1:0] RECIP_100   = 13'd5243;
    localparam int                 RECIP_SHIFT = 19;
    localparam int                 CENT_W      = 8;
    localparam logic [MUL_B_W-1:0] COMMON_YEAR_LEN = 13'd365;

    localparam logic [SPAN_W-1:0] SPAN_MAX = {SPAN_W{1'b1}};

    localparam logic [MONTH_W-1:0] MONTH_JAN = 4'd1;
    localparam logic [MONTH_W-1:0] MONTH_FEB = 4'd2;
    localparam logic [MONTH_W-1:0] MONTH_MAR = 4'd3;
    localparam logic [MONTH_W-1:0] MONTH_MAY = 4'd5;
    localparam logic [MONTH_W-1:0] MONTH_JUL = 4'd7;
    localparam logic [MONTH_W-1:0] MONTH_AUG = 4'd8;
    localparam logic [MONTH_W-1:0] MONTH_OCT = 4'd10;
    localparam logic [MONTH_W-1:0] MONTH_DEC = 4'd12;

    typedef enum logic [2:0] {
        ORD_IDLE,
        ORD_DIV,
        ORD_LEAP,
        ORD_MUL,
        ORD_BASE,
        ORD_MONTH
    } ord_state_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LAUNCH_S,
        ST_WAIT_S,
        ST_LAUNCH_E,
        ST_WAIT_E,
        ST_DONE
    } ids_state_t;

    typedef struct packed {
        logic               start;
        logic [DAY_W-1:0]   day;
        logic [MONTH_W-1:0] month;
        logic [YEAR_W-1:0]  year;
    } ord_req_t;

    typedef struct packed {
        logic             done;
        logic [ORD_W-1:0] ordinal;
    } ord_rsp_t;

    // Length of month m; every month number outside the named sets has 30 days.
    function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] m,
                                                   input logic leap);
        logic [DAY_W-1:0] len;
        if (m == MONTH_FEB) begin
            len = leap ? 5'd29 : 5'd28;
        end
        else if (m inside {MONTH_JAN, MONTH_MAR, MONTH_MAY, MONTH_JUL,
                           MONTH_AUG, MONTH_OCT, MONTH_DEC}) begin
            len = 5'd31;
        end
        else begin
            len = 5'd30;
        end
        return len;
    endfunction

endpackage

// File: hw/rtl/ids_ordinal.sv
// Iterative unit that turns one date into its day ordinal counted from year 0.
module ids_ordinal (
    input  logic              clk,
    input  logic              rst_n,
    input  ids_pkg::ord_req_t req,
    output ids_pkg::ord_rsp_t rsp
);

    ids_pkg::ord_state_t state_reg, state_next;

    logic [ids_pkg::PROD_W-1:0]  prod_reg;
    logic [ids_pkg::ORD_W-1:0]   acc_reg, acc_next;
    logic [ids_pkg::YEAR_W-2:0]  leaps_reg;
    logic                        leap_reg;
    logic [ids_pkg::MONTH_W-1:0] k_reg, k_next;

    logic [ids_pkg::MUL_A_W-1:0] mul_a;
    logic [ids_pkg::MUL_B_W-1:0] mul_b;
    logic [ids_pkg::MUL_A_W-1:0] year_ext;
    logic [ids_pkg::MUL_A_W-1:0] year_p3;
    logic [ids_pkg::CENT_W-1:0]  cent;
    logic [ids_pkg::CENT_W:0]    cent_p3;
    logic [ids_pkg::MUL_A_W-1:0] cent_x100;
    logic                        div100, leap_now;
    logic [ids_pkg::YEAR_W-2:0]  leaps_now;
    logic                        more;

    assign year_ext = {1'b0, req.year};

    // The one multiplier serves both the reciprocal divide and the year scaling.
    always_comb
    begin
        if (state_reg == ids_pkg::ORD_DIV) begin
            mul_a = year_ext + ids_pkg::MUL_A_W'(99);
            mul_b = ids_pkg::RECIP_100;
        end
        else begin
            mul_a = year_ext;
            mul_b = ids_pkg::COMMON_YEAR_LEN;
        end
    end

    // Leap count of all years before y: ceil(y/4) - ceil(y/100) + ceil(y/400).
    always_comb
    begin
        year_p3   = year_ext + ids_pkg::MUL_A_W'(3);
        cent      = prod_reg[ids_pkg::RECIP_SHIFT +: ids_pkg::CENT_W];
        cent_p3   = {1'b0, cent} + 9'd3;
        cent_x100 = ids_pkg::MUL_A_W'(cent) * ids_pkg::MUL_A_W'(100);
        div100    = (cent_x100 == year_ext);
        leap_now  = (req.year[1:0] == 2'b00) && (!div100 || (cent[1:0] == 2'b00));
        leaps_now = year_p3[ids_pkg::MUL_A_W-1:2]
                  - (ids_pkg::YEAR_W-1)'(cent)
                  + (ids_pkg::YEAR_W-1)'(cent_p3[ids_pkg::CENT_W:2]);
    end

    assign more = (k_reg < req.month);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg <= ids_pkg::ORD_IDLE;
        end
        else begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= mul_a * mul_b;
        acc_reg  <= acc_next;
        k_reg    <= k_next;
        if (state_reg == ids_pkg::ORD_LEAP) begin
            leap_reg  <= leap_now;
            leaps_reg <= leaps_now;
        end
    end

    always_comb
    begin
        state_next  = state_reg;
        acc_next    = acc_reg;
        k_next      = k_reg;
        rsp.done    = 1'b0;
        rsp.ordinal = acc_reg;
        case (state_reg)
            ids_pkg::ORD_IDLE: begin
                if (req.start) begin
                    state_next = ids_pkg::ORD_DIV;
                end
            end
            ids_pkg::ORD_DIV: begin
                state_next = ids_pkg::ORD_LEAP;
            end
            ids_pkg::ORD_LEAP: begin
                state_next = ids_pkg::ORD_MUL;
            end
            ids_pkg::ORD_MUL: begin
                state_next = ids_pkg::ORD_BASE;
            end
            ids_pkg::ORD_BASE: begin
                acc_next   = prod_reg[ids_pkg::ORD_W-1:0]
                           + ids_pkg::ORD_W'(leaps_reg)
                           + ids_pkg::ORD_W'(req.day);
                k_next     = ids_pkg::MONTH_JAN;
                state_next = ids_pkg::ORD_MONTH;
            end
            ids_pkg::ORD_MONTH: begin
                if (more) begin
                    acc_next = acc_reg + ids_pkg::ORD_W'(ids_pkg::month_len(k_reg, leap_reg));
                    k_next   = k_reg + 4'd1;
                end
                else begin
                    rsp.done   = 1'b1;
                    state_next = ids_pkg::ORD_IDLE;
                end
            end
            default: begin
                state_next = ids_pkg::ORD_IDLE;
            end
        endcase
    end

endmodule

// File: hw/rtl/inclusive_date_span.sv
// Top level of the inclusive Gregorian date span block.
//
// This block counts the days from a start date through an end date, both
// days included, in the proleptic Gregorian calendar. Each date is turned
// into a day ordinal counted from year 0 by one iterative unit that is used
// first for the start date and then for the end date; the span is the
// difference of the two ordinals plus one. When the end date lies before
// the start date, order_error is set and span_days is 0, and a span beyond
// the 22-bit range saturates. Day and month values are taken as given:
// day 0 adds nothing, months 0 and 1 add no earlier months, and months 13
// to 15 count months 13 and 14 as 30-day months. The input side is ready
// again in the cycle after the result loads. The time an item takes is
// set by the month walk inside the ordinal unit, which adds one month
// length per cycle up to the given month, and by its four setup steps
// that share one multiplier for the leap-year count and the year scaling.
// The input side is not ready while an item is in work. The result sits
// in an output register, so a new input transfer can be taken while the
// previous result still waits.
module inclusive_date_span_core (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic [ids_pkg::DAY_W-1:0]    start_day,
    input  logic [ids_pkg::MONTH_W-1:0]  start_month,
    input  logic [ids_pkg::YEAR_W-1:0]   start_year,
    input  logic [ids_pkg::DAY_W-1:0]    end_day,
    input  logic [ids_pkg::MONTH_W-1:0]  end_month,
    input  logic [ids_pkg::YEAR_W-1:0]   end_year,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic [ids_pkg::SPAN_W-1:0]   span_days,
    output logic                         order_error
);

    ids_pkg::ids_state_t state_reg, state_next;

    // Dates captured at the input transfer.
    logic [ids_pkg::DAY_W-1:0]   sd_reg, ed_reg;
    logic [ids_pkg::MONTH_W-1:0] sm_reg, em_reg;
    logic [ids_pkg::YEAR_W-1:0]  sy_reg, ey_reg;

    logic [ids_pkg::ORD_W-1:0]   os_reg;

    logic                        out_valid_reg, out_valid_next;
    logic [ids_pkg::SPAN_W-1:0]  span_reg;
    logic                        err_reg;

    ids_pkg::ord_req_t ord_req;
    ids_pkg::ord_rsp_t ord_rsp;

    logic                        in_xfer, out_xfer, load_out;
    logic [ids_pkg::ORD_W-1:0]   diff;
    logic [ids_pkg::ORD_W:0]     span_wide;
    logic                        end_early;

    ids_ordinal u_ordinal (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (ord_req),
        .rsp   (ord_rsp)
    );

    assign in_ready = (state_reg == ids_pkg::ST_IDLE);
    assign in_xfer  = in_valid && in_ready;
    assign out_xfer = out_valid_reg && out_ready;

    // The ordinal unit sees the start date until its ordinal is stored,
    // then the end date. Its inputs stay stable while it works.
    always_comb
    begin
        ord_req.start = (state_reg == ids_pkg::ST_LAUNCH_S) ||
                        (state_reg == ids_pkg::ST_LAUNCH_E);
        if ((state_reg == ids_pkg::ST_LAUNCH_E) || (state_reg == ids_pkg::ST_WAIT_E)) begin
            ord_req.day   = ed_reg;
            ord_req.month = em_reg;
            ord_req.year  = ey_reg;
        end
        else begin
            ord_req.day   = sd_reg;
            ord_req.month = sm_reg;
            ord_req.year  = sy_reg;
        end
    end

    // The end ordinal is compared against the stored start ordinal the cycle
    // it comes out of the unit.
    always_comb
    begin
        end_early = (ord_rsp.ordinal < os_reg);
        diff      = ord_rsp.ordinal - os_reg;
        span_wide = {1'b0, diff} + 24'd1;
    end

    always_comb
    begin
        state_next = state_reg;
        load_out   = 1'b0;
        case (state_reg)
            ids_pkg::ST_IDLE: begin
                if (in_xfer) begin
                    state_next = ids_pkg::ST_LAUNCH_S;
                end
            end
            ids_pkg::ST_LAUNCH_S: begin
                state_next = ids_pkg::ST_WAIT_S;
            end
            ids_pkg::ST_WAIT_S: begin
                if (ord_rsp.done) begin
                    state_next = ids_pkg::ST_LAUNCH_E;
                end
            end
            ids_pkg::ST_LAUNCH_E: begin
                state_next = ids_pkg::ST_WAIT_E;
            end
            ids_pkg::ST_WAIT_E: begin
                if (ord_rsp.done) begin
                    state_next = ids_pkg::ST_DONE;
                end
            end
            ids_pkg::ST_DONE: begin
                // Holds here until the output register is free.
                if (!out_valid_reg || out_ready) begin
                    load_out   = 1'b1;
                    state_next = ids_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = ids_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (load_out) begin
            out_valid_next = 1'b1;
        end
        else if (out_xfer) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg     <= ids_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers, no reset needed.
    logic                       err_hold_reg;
    logic [ids_pkg::SPAN_W-1:0] span_hold_reg;

    always_ff @(posedge clk)
    begin
        if (in_xfer) begin
            sd_reg <= start_day;
            sm_reg <= start_month;
            sy_reg <= start_year;
            ed_reg <= end_day;
            em_reg <= end_month;
            ey_reg <= end_year;
        end
        if ((state_reg == ids_pkg::ST_WAIT_S) && ord_rsp.done) begin
            os_reg <= ord_rsp.ordinal;
        end
        if ((state_reg == ids_pkg::ST_WAIT_E) && ord_rsp.done) begin
            err_hold_reg <= end_early;
            if (end_early) begin
                span_hold_reg <= '0;
            end
            else if (span_wide > (ids_pkg::ORD_W + 1)'(ids_pkg::SPAN_MAX)) begin
                span_hold_reg <= ids_pkg::SPAN_MAX;
            end
            else begin
                span_hold_reg <= span_wide[ids_pkg::SPAN_W-1:0];
            end
        end
        if (load_out) begin
            span_reg <= span_hold_reg;
            err_reg  <= err_hold_reg;
        end
    end

    assign out_valid   = out_valid_reg;
    assign span_days   = span_reg;
    assign order_error = err_reg;

endmodule

// File: hw/rtl/ids_checker.sv
// Port-level checker for the date span block and its bind to the top level.
module ids_checker (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    input  logic                         in_ready,
    input  logic                         out_valid,
    input  logic                         out_ready,
    input  logic [ids_pkg::SPAN_W-1:0]   span_days,
    input  logic                         order_error
);

    // A reversed pair of dates always reports an empty span.
    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && order_error |-> span_days == '0)
        else $error("order_error result with nonzero span_days");

    // A correct order always counts at least the start day.
    a_span_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !order_error |-> span_days != '0)
        else $error("valid span of zero days without order_error");

    // The block works on one item at a time.
    a_busy_after_take: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("input taken again in the cycle after a transfer");

    // A stalled result holds.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(span_days) && $stable(order_error))
        else $error("stalled result changed or dropped");

endmodule

bind inclusive_date_span_core ids_checker u_ids_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .span_days   (span_days),
    .order_error (order_error)
);

// File: sim/testbench.sv
`timescale 1ns / 1ps
// Self-checking testbench of the inclusive date span core: directed date pairs, then random ones.
module testbench;

    localparam int DAY_W   = ids_pkg::DAY_W;
    localparam int MONTH_W = ids_pkg::MONTH_W;
    localparam int YEAR_W  = ids_pkg::YEAR_W;
    localparam int SPAN_W  = ids_pkg::SPAN_W;
    localparam logic [SPAN_W-1:0] SPAN_MAX = ids_pkg::SPAN_MAX;

    localparam int CLK_HALF         = 5;
    localparam int RESET_CYCLES     = 10;
    localparam int NUM_PHASES       = 4;
    localparam int RANDOM_PER_PHASE = 385;
    localparam int HOLD_CYCLES      = 400;
    localparam int DRAIN_CYCLES     = 100;
    localparam int WATCHDOG_LIMIT   = 4000;
    localparam int REPORT_LIMIT     = 10;
    localparam int NUM_DIRECTED     = 24;
    localparam int unsigned YEAR_MAX_REAL = 9999;

    // Percent of cycles in which the sender idles and the receiver stalls, per phase.
    localparam int unsigned SEND_IDLE_PCT  [NUM_PHASES] = '{0, 76, 0, 12};
    localparam int unsigned RECV_STALL_PCT [NUM_PHASES] = '{0, 0, 76, 12};

    typedef struct packed {
        logic [SPAN_W-1:0] span;
        logic              order_err;
    } span_result_t;

    // One directed row: the date pair, and a typed result where known_result is set.
    typedef struct packed {
        logic [DAY_W-1:0]   sd;
        logic [MONTH_W-1:0] sm;
        logic [YEAR_W-1:0]  sy;
        logic [DAY_W-1:0]   ed;
        logic [MONTH_W-1:0] em;
        logic [YEAR_W-1:0]  ey;
        logic               known_result;
        span_result_t       result;
    } date_row_t;

    // Rows with known_result cleared carry a dummy result and go to the predictor.
    localparam date_row_t DIRECTED_ROWS [NUM_DIRECTED] = '{
        // A single day, at the low and at the high end of the real range.
        '{5'd1,  4'd1,  14'd1,     5'd1,  4'd1,  14'd1,     1'b1, '{22'd1, 1'b0}},
        '{5'd31, 4'd12, 14'd9999,  5'd31, 4'd12, 14'd9999,  1'b1, '{22'd1, 1'b0}},
        // The whole real range.
        '{5'd1,  4'd1,  14'd1,     5'd31, 4'd12, 14'd9999,  1'b1, '{22'd3652059, 1'b0}},
        // End one day before start.
        '{5'd2,  4'd1,  14'd2000,  5'd1,  4'd1,  14'd2000,  1'b1, '{22'd0, 1'b1}},
        // Full leap year, full century non-leap year, year zero.
        '{5'd1,  4'd1,  14'd2000,  5'd31, 4'd12, 14'd2000,  1'b1, '{22'd366, 1'b0}},
        '{5'd1,  4'd1,  14'd1900,  5'd31, 4'd12, 14'd1900,  1'b1, '{22'd365, 1'b0}},
        '{5'd1,  4'd1,  14'd0,     5'd31, 4'd12, 14'd0,     1'b1, '{22'd366, 1'b0}},
        // Widest possible span saturates; reversed it is an order error.
        '{5'd0,  4'd0,  14'd0,     5'd31, 4'd15, 14'd16383, 1'b1, '{SPAN_MAX, 1'b0}},
        '{5'd31, 4'd15, 14'd16383, 5'd0,  4'd0,  14'd0,     1'b1, '{22'd0, 1'b1}},
        '{5'd31, 4'd15, 14'd16383, 5'd31, 4'd15, 14'd16383, 1'b1, '{22'd1, 1'b0}},
        '{5'd0,  4'd0,  14'd0,     5'd0,  4'd0,  14'd0,     1'b1, '{22'd1, 1'b0}},
        // February in a leap and in a common year.
        '{5'd28, 4'd2,  14'd2024,  5'd1,  4'd3,  14'd2024,  1'b0, '{22'd0, 1'b0}},
        '{5'd28, 4'd2,  14'd2023,  5'd1,  4'd3,  14'd2023,  1'b0, '{22'd0, 1'b0}},
        // Day zero, and month zero against January.
        '{5'd0,  4'd1,  14'd2000,  5'd1,  4'd1,  14'd2000,  1'b0, '{22'd0, 1'b0}},
        '{5'd1,  4'd0,  14'd2000,  5'd1,  4'd1,  14'd2000,  1'b0, '{22'd0, 1'b0}},
        // Out-of-range months 13 and 14.
        '{5'd1,  4'd13, 14'd2023,  5'd1,  4'd14, 14'd2023,  1'b0, '{22'd0, 1'b0}},
        // The rest of the start year must use the start year's leap status.
        '{5'd1,  4'd3,  14'd2000,  5'd1,  4'd3,  14'd2001,  1'b0, '{22'd0, 1'b0}},
        '{5'd1,  4'd1,  14'd2000,  5'd1,  4'd3,  14'd2001,  1'b0, '{22'd0, 1'b0}},
        '{5'd15, 4'd6,  14'd2100,  5'd15, 4'd6,  14'd2101,  1'b0, '{22'd0, 1'b0}},
        '{5'd1,  4'd1,  14'd1600,  5'd1,  4'd1,  14'd2400,  1'b0, '{22'd0, 1'b0}},
        // An unchecked day 31 in February overtakes the first of March.
        '{5'd31, 4'd2,  14'd2023,  5'd1,  4'd3,  14'd2023,  1'b0, '{22'd0, 1'b0}},
        '{5'd1,  4'd1,  14'd2,     5'd31, 4'd12, 14'd1,     1'b0, '{22'd0, 1'b0}},
        '{5'd31, 4'd12, 14'd1999,  5'd1,  4'd1,  14'd2000,  1'b0, '{22'd0, 1'b0}},
        '{5'd31, 4'd15, 14'd0,     5'd0,  4'd0,  14'd16383, 1'b0, '{22'd0, 1'b0}}
    };

    logic                clk         = 1'b0;
    logic                rst_n       = 1'b0;
    logic                in_valid    = 1'b0;
    logic                in_ready;
    logic [DAY_W-1:0]    start_day   = '0;
    logic [MONTH_W-1:0]  start_month = '0;
    logic [YEAR_W-1:0]   start_year  = '0;
    logic [DAY_W-1:0]    end_day     = '0;
    logic [MONTH_W-1:0]  end_month   = '0;
    logic [YEAR_W-1:0]   end_year    = '0;
    logic                out_valid;
    logic                out_ready   = 1'b0;
    logic [SPAN_W-1:0]   span_days;
    logic                order_error;

    // Spans the block still owes, oldest first.
    span_result_t span_expect_q [$];

    int unsigned send_idle_pct  = 0;
    int unsigned recv_stall_pct = 0;
    int          mismatch_count = 0;
    // The sender asks for a long receiver hold-off by raising hold_requests.
    int          hold_requests  = 0;
    int          hold_served    = 0;

    inclusive_date_span_core u_top (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .start_day   (start_day),
        .start_month (start_month),
        .start_year  (start_year),
        .end_day     (end_day),
        .end_month   (end_month),
        .end_year    (end_year),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .span_days   (span_days),
        .order_error (order_error)
    );

    initial
    begin
        forever
        begin
            #CLK_HALF clk = ~clk;
        end
    end

    // Gregorian leap rule; year zero counts as a leap year.
    function automatic bit is_leap_year(input int unsigned y);
        return (y % 4 == 0) && ((y % 100 != 0) || (y % 400 == 0));
    endfunction

    // Every month number outside the 31-day set and February has 30 days,
    // which also covers the unchecked months 0 and 13 to 15.
    function automatic int unsigned month_days(input int unsigned m, input int unsigned y);
        int unsigned len;
        if (m == ids_pkg::MONTH_FEB)
        begin
            len = is_leap_year(y) ? 29 : 28;
        end
        else if (m == ids_pkg::MONTH_JAN || m == ids_pkg::MONTH_MAR ||
                 m == ids_pkg::MONTH_MAY || m == ids_pkg::MONTH_JUL ||
                 m == ids_pkg::MONTH_AUG || m == ids_pkg::MONTH_OCT ||
                 m == ids_pkg::MONTH_DEC)
        begin
            len = 31;
        end
        else
        begin
            len = 30;
        end
        return len;
    endfunction

    // Days from the start of year zero through the given date.
    function automatic longint unsigned date_ordinal(input int unsigned d, input int unsigned m,
                                                     input int unsigned y);
        longint unsigned total;
        total = longint'(y) * 365 + (y + 3) / 4 - (y + 99) / 100 + (y + 399) / 400 + d;
        for (int unsigned k = 1; k < m; k++)
        begin
            total += month_days(k, y);
        end
        return total;
    endfunction

    // Inclusive day count between two dates, with the order flag and saturation.
    function automatic span_result_t predict_span(input logic [DAY_W-1:0] sd,
                                                  input logic [MONTH_W-1:0] sm,
                                                  input logic [YEAR_W-1:0] sy,
                                                  input logic [DAY_W-1:0] ed,
                                                  input logic [MONTH_W-1:0] em,
                                                  input logic [YEAR_W-1:0] ey);
        longint unsigned ord_start;
        longint unsigned ord_end;
        longint unsigned days;
        span_result_t    res;
        ord_start = date_ordinal(int'(sd), int'(sm), int'(sy));
        ord_end   = date_ordinal(int'(ed), int'(em), int'(ey));
        if (ord_end < ord_start)
        begin
            res.span      = '0;
            res.order_err = 1'b1;
        end
        else
        begin
            days = ord_end - ord_start + 1;
            if (days > longint'(SPAN_MAX))
            begin
                days = longint'(SPAN_MAX);
            end
            res.span      = days[SPAN_W-1:0];
            res.order_err = 1'b0;
        end
        return res;
    endfunction

    // Offers one date pair and returns at the edge where it transfers. Valid is
    // lowered only when an idle gap follows, so it never drops and rises within
    // one time step.
    task automatic send_dates(input logic [DAY_W-1:0] sd, input logic [MONTH_W-1:0] sm,
                              input logic [YEAR_W-1:0] sy, input logic [DAY_W-1:0] ed,
                              input logic [MONTH_W-1:0] em, input logic [YEAR_W-1:0] ey,
                              input logic known_result, input span_result_t typed_result);
        if ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            do
            begin
                @(posedge clk);
            end
            while ($urandom_range(99) < send_idle_pct);
        end
        in_valid    <= 1'b1;
        start_day   <= sd;
        start_month <= sm;
        start_year  <= sy;
        end_day     <= ed;
        end_month   <= em;
        end_year    <= ey;
        do
        begin
            @(posedge clk);
        end
        while (!in_ready);
        if (known_result)
        begin
            span_expect_q.push_back(typed_result);
        end
        else
        begin
            span_expect_q.push_back(predict_span(sd, sm, sy, ed, em, ey));
        end
    endtask

    // Sender: reset, the directed table, then the random phases, then the drain.
    initial
    begin
        logic [DAY_W-1:0]   sd;
        logic [DAY_W-1:0]   ed;
        logic [MONTH_W-1:0] sm;
        logic [MONTH_W-1:0] em;
        logic [YEAR_W-1:0]  sy;
        logic [YEAR_W-1:0]  ey;
        int unsigned        kind;
        int unsigned        year_step;

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < NUM_DIRECTED; i++)
        begin
            send_dates(DIRECTED_ROWS[i].sd, DIRECTED_ROWS[i].sm, DIRECTED_ROWS[i].sy,
                       DIRECTED_ROWS[i].ed, DIRECTED_ROWS[i].em, DIRECTED_ROWS[i].ey,
                       DIRECTED_ROWS[i].known_result, DIRECTED_ROWS[i].result);
        end

        for (int phase = 0; phase < NUM_PHASES; phase++)
        begin
            send_idle_pct  = SEND_IDLE_PCT[phase];
            recv_stall_pct = RECV_STALL_PCT[phase];
            for (int i = 0; i < RANDOM_PER_PHASE; i++)
            begin
                // In the first and the last phase the receiver goes quiet for a while, so the
                // output register and the ordinal unit fill and the input stalls.
                if ((phase == 0 || phase == NUM_PHASES - 1) && i == 8)
                begin
                    hold_requests++;
                end
                kind = $urandom_range(99);
                if (kind < 75)
                begin
                    // Well-formed calendar dates; the day is legal for its month.
                    sy = YEAR_W'($urandom_range(YEAR_MAX_REAL, 1));
                    sm = MONTH_W'($urandom_range(12, 1));
                    sd = DAY_W'($urandom_range(month_days(int'(sm), int'(sy)), 1));
                    if (kind < 45)
                    begin
                        // Short forward span of a few years at most.
                        year_step = $urandom_range(3);
                        ey = (int'(sy) + year_step > YEAR_MAX_REAL) ? sy
                                                                   : sy + YEAR_W'(year_step);
                        em = (ey == sy) ? MONTH_W'($urandom_range(12, int'(sm)))
                                        : MONTH_W'($urandom_range(12, 1));
                        if (ey == sy && em == sm)
                        begin
                            ed = DAY_W'($urandom_range(month_days(int'(em), int'(ey)),
                                                       int'(sd)));
                        end
                        else
                        begin
                            ed = DAY_W'($urandom_range(month_days(int'(em), int'(ey)), 1));
                        end
                    end
                    else
                    begin
                        // Either order: same year, or anywhere in the real range.
                        ey = (kind < 60) ? sy : YEAR_W'($urandom_range(YEAR_MAX_REAL, 1));
                        em = MONTH_W'($urandom_range(12, 1));
                        ed = DAY_W'($urandom_range(month_days(int'(em), int'(ey)), 1));
                    end
                end
                else
                begin
                    // Raw field values, including unchecked days, months and years.
                    sd = DAY_W'($urandom);
                    sm = MONTH_W'($urandom);
                    sy = YEAR_W'($urandom);
                    ed = DAY_W'($urandom);
                    em = MONTH_W'($urandom);
                    ey = YEAR_W'($urandom);
                end
                send_dates(sd, sm, sy, ed, em, ey, 1'b0, '0);
            end
        end

        in_valid <= 1'b0;
        while (span_expect_q.size() != 0)
        begin
            @(posedge clk);
        end
        // Stray results after the last expected one still count as failures.
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatch_count == 0 && span_expect_q.size() == 0)
        begin
            $display("All tests passed");
        end
        else
        begin
            $display("Some tests failed");
        end
        $finish;
    end

    // Receiver: checks every result transfer and drives out_ready.
    initial
    begin
        span_result_t want;
        int           hold_left;
        hold_left = 0;
        forever
        begin
            @(posedge clk);
            if (out_valid && out_ready)
            begin
                if (span_expect_q.size() == 0)
                begin
                    mismatch_count++;
                    if (mismatch_count <= REPORT_LIMIT)
                    begin
                        $display("Unexpected result: span_days %0d, order_error %0b",
                                 span_days, order_error);
                    end
                end
                else
                begin
                    want = span_expect_q.pop_front();
                    if (span_days !== want.span || order_error !== want.order_err)
                    begin
                        mismatch_count++;
                        if (mismatch_count <= REPORT_LIMIT)
                        begin
                            $display("Mismatch: span_days %0d (expected %0d), %s %0b %s %0b)",
                                     span_days, want.span, "order_error", order_error,
                                     "(expected", want.order_err);
                        end
                    end
                end
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_ready <= 1'b0;
            end
            else if (hold_served != hold_requests)
            begin
                hold_served = hold_requests;
                hold_left   = HOLD_CYCLES;
                out_ready   <= 1'b0;
            end
            else
            begin
                out_ready <= ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    // Watchdog: ends the run when no transfer happens on either side for too long.
    initial
    begin
        int quiet_cycles;
        quiet_cycles = 0;
        while (quiet_cycles < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid && in_ready) || (out_valid && out_ready))
            begin
                quiet_cycles = 0;
            end
            else
            begin
                quiet_cycles++;
            end
        end
        $display("Some tests failed");
        $finish;
    end

endmodule
